>>> design/api_frame_receiver_checksum_macros.svh
// Assertion macros shared by the frame receiver modules.
`ifndef API_FRAME_RECEIVER_CHECKSUM_MACROS_SVH
`define API_FRAME_RECEIVER_CHECKSUM_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define AFRC_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define AFRC_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> design/afrc_pkg.sv
// Shared types and constants of the API frame receiver.
package afrc_pkg;

   // Largest frame, start byte through checksum byte
   localparam int unsigned MAX_FRAME = 64;

   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 8;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_DELIMITER     = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACCEPTED_FRAME_TYPE = 1'd1;

   // Configuration reset values
   localparam logic [7:0] START_DELIMITER_RESET     = 8'h7E;
   localparam logic [7:0] ACCEPTED_FRAME_TYPE_RESET = 8'h10;

   // Result kinds
   localparam logic [1:0] KIND_NONE      = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
   localparam logic [1:0] KIND_FRAME_END = 2'd2;

   // One result transaction
   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] payload_byte;
      logic [5:0] payload_index;
      logic [5:0] frame_len_field;
      logic       checksum_ok;
      logic       frame_last;
   } afrc_result_type;

endpackage

>>> design/api_frame_receiver_checksum.sv
// API frame receiver: finds framed messages in a byte stream, emits payload
// bytes with their index and reports each frame end with a checksum flag.
// Every accepted byte yields exactly one result transaction in the next cycle;
// a new byte is taken every cycle while the result register drains, so the
// sustained rate is one byte per clock, set by the single parser stage
// between the running state and the result register.
`include "api_frame_receiver_checksum_macros.svh"

module api_frame_receiver_checksum (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_result_kind,
   output logic [7:0]                           rsp_payload_byte,
   output logic [5:0]                           rsp_payload_index,
   output logic [5:0]                           rsp_frame_len_field,
   output logic                                 rsp_checksum_ok,
   output logic                                 rsp_frame_last,
   input  logic                                 csr_we,
   input  logic [afrc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [afrc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import afrc_pkg::*;

   logic [7:0]      start_delimiter_ff;
   logic [7:0]      accepted_frame_type_ff;
   logic            rsp_valid_ff;
   afrc_result_type rsp_data_ff;
   afrc_result_type result;
   logic            accept;

   // Take a byte whenever the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_delimiter_ff     <= START_DELIMITER_RESET;
         accepted_frame_type_ff <= ACCEPTED_FRAME_TYPE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_DELIMITER:     start_delimiter_ff     <= csr_wdata;
            CSR_ACCEPTED_FRAME_TYPE: accepted_frame_type_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   afrc_parse u_parse (
      .clock               (clock),
      .reset               (reset),
      .step                (accept),
      .rx_byte             (req_rx_byte),
      .start_delimiter     (start_delimiter_ff),
      .accepted_frame_type (accepted_frame_type_ff),
      .result              (result)
   );

   // Track result register occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the result transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_data_ff.result_kind;
   assign rsp_payload_byte    = rsp_data_ff.payload_byte;
   assign rsp_payload_index   = rsp_data_ff.payload_index;
   assign rsp_frame_len_field = rsp_data_ff.frame_len_field;
   assign rsp_checksum_ok     = rsp_data_ff.checksum_ok;
   assign rsp_frame_last      = rsp_data_ff.frame_last;

   `AFRC_ASSERT_NEXT(a_accept_gives_result, clock, reset,
      accept, rsp_valid_ff,
      "accepted byte produced no result")
   `AFRC_ASSERT_SAME(a_last_matches_kind, clock, reset,
      rsp_valid_ff, rsp_frame_last == (rsp_result_kind == KIND_FRAME_END),
      "frame_last disagrees with result kind")
   `AFRC_ASSERT_SAME(a_idle_result_clean, clock, reset,
      rsp_valid_ff && (rsp_result_kind == KIND_NONE),
      (rsp_payload_byte == 8'h00) && !rsp_checksum_ok && (rsp_frame_len_field == 6'd0),
      "empty result carries data")

endmodule

>>> design/afrc_parse.sv
// Frame parser: sync detection, running sum and checksum check per byte.
`include "api_frame_receiver_checksum_macros.svh"

module afrc_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               rx_byte,
   input  logic [7:0]               start_delimiter,
   input  logic [7:0]               accepted_frame_type,
   output afrc_pkg::afrc_result_type result
);
   import afrc_pkg::*;

   logic [7:0] recent0_ff, recent1_ff, recent2_ff;
   logic       in_frame_ff, in_frame_in;
   logic [6:0] byte_count_ff, byte_count_in;
   logic [6:0] expected_length_ff, expected_length_in;
   logic [7:0] running_sum_ff, running_sum_in;

   logic       sync;
   logic       drop;
   logic [8:0] span;
   logic [6:0] count_inc;
   logic [6:0] frame_len;
   logic [6:0] index_raw;

   // Detect the sync pattern and length limits
   assign sync = (recent2_ff == start_delimiter) && (recent1_ff == 8'h00) &&
                 (rx_byte == accepted_frame_type);
   assign span = {1'b0, recent0_ff} + 9'd4;
   assign drop = (recent0_ff == 8'h00) || (span > 9'(MAX_FRAME));
   assign count_inc = byte_count_ff + 7'd1;
   assign frame_len = expected_length_ff - 7'd3;
   assign index_raw = count_inc - 7'd4;

   // Compute the result and the next frame state
   always_comb begin
      result             = '0;
      in_frame_in        = in_frame_ff;
      byte_count_in      = byte_count_ff;
      expected_length_in = expected_length_ff;
      running_sum_in     = running_sum_ff;
      if (sync) begin
         if (drop) begin
            in_frame_in = 1'b0;
         end else begin
            in_frame_in        = 1'b1;
            byte_count_in      = 7'd3;
            expected_length_in = recent0_ff[6:0] + 7'd3;
            running_sum_in     = rx_byte;
         end
      end else if (in_frame_ff) begin
         byte_count_in          = count_inc;
         result.frame_len_field = frame_len[5:0];
         if (count_inc < expected_length_ff) begin
            running_sum_in       = running_sum_ff + rx_byte;
            result.result_kind   = KIND_PAYLOAD;
            result.payload_byte  = rx_byte;
            result.payload_index = index_raw[5:0];
         end else begin
            result.result_kind = KIND_FRAME_END;
            result.frame_last  = 1'b1;
            result.checksum_ok = ((8'hFF - running_sum_ff) == rx_byte);
            in_frame_in        = 1'b0;
         end
      end
   end

   // Advance the state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         recent0_ff         <= '0;
         recent1_ff         <= '0;
         recent2_ff         <= '0;
         in_frame_ff        <= 1'b0;
         byte_count_ff      <= '0;
         expected_length_ff <= '0;
         running_sum_ff     <= '0;
      end else if (step) begin
         recent0_ff         <= rx_byte;
         recent1_ff         <= recent0_ff;
         recent2_ff         <= recent1_ff;
         in_frame_ff        <= in_frame_in;
         byte_count_ff      <= byte_count_in;
         expected_length_ff <= expected_length_in;
         running_sum_ff     <= running_sum_in;
      end
   end

   `AFRC_ASSERT_NEXT(a_end_leaves_frame, clock, reset,
      step && (result.result_kind == KIND_FRAME_END), !in_frame_ff,
      "frame end did not return to hunting")
   `AFRC_ASSERT_SAME(a_frame_count_bound, clock, reset,
      in_frame_ff, byte_count_ff < expected_length_ff,
      "byte count ran past the checksum position")
   `AFRC_ASSERT_NEXT(a_sync_starts_frame, clock, reset,
      step && sync && !drop, in_frame_ff && (byte_count_ff == 7'd3),
      "accepted sync did not open a frame")

endmodule

>>> sim/api_frame_receiver_checksum_test.sv
// Self-checking testbench for the API frame receiver with checksum check.
`timescale 1ns / 100ps

module api_frame_receiver_checksum_test;
   import afrc_pkg::*;

   localparam int PHASE_ITEMS = 240;
   localparam int LONG_HOLD   = 300;
   localparam int STALL_LIMIT = 2000;

   // Predicts one result per accepted byte and checks results in order
   class frame_scoreboard;
      logic [7:0]      start_byte;
      logic [7:0]      type_byte;
      logic [7:0]      history [3];
      bit              in_frame;
      logic [6:0]      position;
      logic [6:0]      checksum_pos;
      logic [7:0]      sum;
      afrc_result_type pending_results [$];
      int              errors;
      int              results_seen;

      function new();
         start_byte   = START_DELIMITER_RESET;
         type_byte    = ACCEPTED_FRAME_TYPE_RESET;
         history      = '{8'h00, 8'h00, 8'h00};
         in_frame     = 1'b0;
         position     = '0;
         checksum_pos = '0;
         sum          = '0;
         errors       = 0;
         results_seen = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] idx, logic [7:0] value);
         case (idx)
            CSR_START_DELIMITER:     start_byte = value;
            CSR_ACCEPTED_FRAME_TYPE: type_byte  = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // Advance the parser by one accepted byte and queue its result
      function void note_byte(logic [7:0] rx);
         afrc_result_type want;
         logic [6:0]      span;
         logic [6:0]      idx;
         logic [7:0]      good_sum;
         want = '0;
         if (history[2] == start_byte && history[1] == 8'h00 && rx == type_byte) begin
            // sync: drop zero-length and oversized frames, else restart the frame
            if (history[0] == 8'h00 || int'(history[0]) + 4 > int'(MAX_FRAME)) begin
               in_frame = 1'b0;
            end else begin
               in_frame     = 1'b1;
               position     = 7'd3;
               checksum_pos = history[0][6:0] + 7'd3;
               sum          = rx;
            end
         end else if (in_frame) begin
            span     = checksum_pos - 7'd3;
            position = position + 7'd1;
            want.frame_len_field = span[5:0];
            if (position < checksum_pos) begin
               sum                = sum + rx;
               idx                = position - 7'd4;
               want.result_kind   = KIND_PAYLOAD;
               want.payload_byte  = rx;
               want.payload_index = idx[5:0];
            end else begin
               good_sum           = 8'hFF - sum;
               want.result_kind   = KIND_FRAME_END;
               want.frame_last    = 1'b1;
               want.checksum_ok   = (good_sum == rx);
               in_frame           = 1'b0;
            end
         end
         history[2] = history[1];
         history[1] = history[0];
         history[0] = rx;
         pending_results.push_back(want);
      endfunction

      function void field_ok(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(afrc_result_type got);
         afrc_result_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result transaction with no byte pending");
            errors++;
            return;
         end
         want = pending_results.pop_front();
         field_ok("result_kind", want.result_kind, got.result_kind);
         field_ok("payload_byte", want.payload_byte, got.payload_byte);
         field_ok("payload_index", want.payload_index, got.payload_index);
         field_ok("frame_len_field", want.frame_len_field, got.frame_len_field);
         field_ok("checksum_ok", want.checksum_ok, got.checksum_ok);
         field_ok("frame_last", want.frame_last, got.frame_last);
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [7:0]                 req_rx_byte;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [1:0]                 rsp_result_kind;
   logic [7:0]                 rsp_payload_byte;
   logic [5:0]                 rsp_payload_index;
   logic [5:0]                 rsp_frame_len_field;
   logic                       rsp_checksum_ok;
   logic                       rsp_frame_last;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   frame_scoreboard sb;
   logic [7:0]      tx_queue [$];
   logic [7:0]      tx_sum;
   logic [7:0]      cur_start;
   logic [7:0]      cur_type;
   int              items_sent;
   int              burst_left;

   api_frame_receiver_checksum DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_payload_index   (rsp_payload_index),
      .rsp_frame_len_field (rsp_frame_len_field),
      .rsp_checksum_ok     (rsp_checksum_ok),
      .rsp_frame_last      (rsp_frame_last),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Check every result transaction against the oldest prediction
   always @(posedge clock) begin
      afrc_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.result_kind     = rsp_result_kind;
         got.payload_byte    = rsp_payload_byte;
         got.payload_index   = rsp_payload_index;
         got.frame_len_field = rsp_frame_len_field;
         got.checksum_ok     = rsp_checksum_ok;
         got.frame_last      = rsp_frame_last;
         sb.check_result(got);
      end
   end

   // Receiver: switch between stall patterns, with two long hold-offs
   initial begin : receiver
      int mode;
      int mode_left;
      int holds_done;
      rsp_ready <= 1'b0;
      mode       = 0;
      mode_left  = 0;
      holds_done = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (holds_done < 2 && sb.results_seen >= 150 + holds_done * 550) begin
            holds_done++;
            repeat (LONG_HOLD) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= (mode_left % 3) != 0;
               2: rsp_ready <= ($urandom_range(0, 1) == 1);
               default: rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // End the run when no transaction moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Frame builders: queue bytes under the current delimiter and type
   function automatic void add_byte(logic [7:0] b);
      tx_queue.push_back(b);
      tx_sum = tx_sum + b;
   endfunction

   function automatic void add_header(logic [7:0] len);
      tx_queue.push_back(cur_start);
      tx_queue.push_back(8'h00);
      tx_queue.push_back(len);
      tx_queue.push_back(cur_type);
      tx_sum = cur_type;
   endfunction

   function automatic void add_checksum(bit corrupt);
      logic [7:0] cs;
      cs = 8'hFF - tx_sum;
      if (corrupt)
         cs = cs ^ 8'($urandom_range(1, 255));
      tx_queue.push_back(cs);
   endfunction

   function automatic void add_frame(int len, bit corrupt);
      add_header(8'(len));
      repeat (len - 1) add_byte(8'($urandom_range(0, 255)));
      add_checksum(corrupt);
   endfunction

   // Mostly short frames, now and then long ones up to the largest
   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 8);
      else if (r < 95)
         return $urandom_range(9, 40);
      else
         return int'(MAX_FRAME) - 4;
   endfunction

   function automatic void add_random_unit();
      int r;
      int len;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         add_frame(pick_len(), 1'b0);
      end else if (r < 78) begin
         add_frame(pick_len(), 1'b1);
      end else if (r < 86) begin
         // cut the frame short; the next header resyncs or noise runs on
         len = pick_len() + 1;
         add_header(8'(len));
         repeat ($urandom_range(0, len - 2)) add_byte(8'($urandom_range(0, 255)));
      end else if (r < 93) begin
         case ($urandom_range(0, 2))
            0: add_header(8'h00);
            1: add_header(8'(int'(MAX_FRAME) - 3));
            default: add_header(8'($urandom_range(int'(MAX_FRAME) - 3, 255)));
         endcase
      end else begin
         repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   // Send the queued bytes in bursts with random gaps
   task automatic play_bytes();
      logic [7:0] b;
      int         gap;
      while (tx_queue.size() > 0) begin
         b = tx_queue.pop_front();
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         req_valid   <= 1'b1;
         req_rx_byte <= b;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         sb.note_byte(b);
         items_sent++;
      end
   endtask

   // Hold the input until every predicted result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] idx, logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      sb.set_register(idx, value);
      if (idx == CSR_START_DELIMITER)
         cur_start = value;
      else
         cur_type = value;
   endtask

   initial begin : stimulus
      int  target;
      bit  paused;
      req_valid   <= 1'b0;
      req_rx_byte <= 8'h00;
      csr_we      <= 1'b0;
      csr_index   <= CSR_START_DELIMITER;
      csr_wdata   <= '0;
      reset       <= 1'b1;
      sb          = new();
      cur_start   = START_DELIMITER_RESET;
      cur_type    = ACCEPTED_FRAME_TYPE_RESET;
      tx_sum      = '0;
      items_sent  = 0;
      burst_left  = 0;
      paused      = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: good frame with extreme payload, zero length, too long,
      // a cut frame resynced by a header, and a bad checksum
      add_header(8'd3);
      add_byte(8'h00);
      add_byte(8'hFF);
      add_checksum(1'b0);
      add_header(8'h00);
      add_header(8'(int'(MAX_FRAME) - 3));
      add_header(8'd2);
      add_byte(8'hA5);
      add_header(8'd1);
      add_checksum(1'b1);
      play_bytes();

      // Random phases; every phase after the first sets both registers anew
      for (int phase = 0; phase < 5; phase++) begin
         if (phase > 0) begin
            wait_drained();
            case (phase)
               1: begin
                  write_register(CSR_START_DELIMITER, 8'h00);
                  write_register(CSR_ACCEPTED_FRAME_TYPE, 8'h00);
               end
               2: begin
                  write_register(CSR_START_DELIMITER, 8'hFF);
                  write_register(CSR_ACCEPTED_FRAME_TYPE, 8'hFF);
               end
               3: begin
                  write_register(CSR_START_DELIMITER, 8'($urandom_range(0, 255)));
                  write_register(CSR_ACCEPTED_FRAME_TYPE, 8'($urandom_range(0, 255)));
               end
               default: begin
                  write_register(CSR_START_DELIMITER, START_DELIMITER_RESET);
                  write_register(CSR_ACCEPTED_FRAME_TYPE, ACCEPTED_FRAME_TYPE_RESET);
               end
            endcase
         end
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            // in phase 2, pause the sender once mid-phase until all results are back
            if (phase == 2 && !paused && items_sent > target - PHASE_ITEMS / 2) begin
               wait_drained();
               paused = 1'b1;
            end
            add_random_unit();
            play_bytes();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> api_frame_receiver_checksum.f
+incdir+design
design/afrc_pkg.sv
design/afrc_parse.sv
design/api_frame_receiver_checksum.sv
sim/api_frame_receiver_checksum_test.sv
